// ----- rtl/y2b_pkg.sv -----
// ----------------------------------------------------------------------------
// y2b_pkg: YUV to BGR converter shared types and constants
// Q10 matrix coefficients for both matrix modes and the output clamp.
// ----------------------------------------------------------------------------
package y2b_pkg;

    // Signed accumulator wide enough for any sum in Q10 (|sum| < 2^20).
    typedef logic signed [21:0] t_acc;
    typedef logic signed [12:0] t_coef;
    typedef logic        [7:0]  t_byte;

    localparam int unsigned FRAC_BITS = 10;

    // Matrix select codes
    localparam logic MODE_STUDIO = 1'b0;
    localparam logic MODE_ALT    = 1'b1;

    // Studio range BT.601, but with the U and V green weights swapped: 1.164, 2.018, 0.813, 0.391, 1.596
    localparam t_coef C0_Y  = 13'sd1192;
    localparam t_coef C0_UB = 13'sd2066;
    localparam t_coef C0_UG = -13'sd833;
    localparam t_coef C0_VG = -13'sd400;
    localparam t_coef C0_VR = 13'sd1634;

    // Alternate matrix, luma unscaled: 2.12798, 0.21482, 0.38059, 1.28033
    localparam t_coef C1_UB = 13'sd2179;
    localparam t_coef C1_UG = -13'sd220;
    localparam t_coef C1_VG = -13'sd390;
    localparam t_coef C1_VR = 13'sd1311;

    localparam logic signed [9:0] LUMA_OFS   = 10'sd16;
    localparam logic signed [9:0] CHROMA_OFS = 10'sd128;

    // Floor by arithmetic shift, then clamp to 0..255.
    function automatic t_byte clamp_byte(input t_acc acc);
        logic signed [11:0] q;
        q = 12'(acc >>> FRAC_BITS);
        if (q < 12'sd0) begin
            return 8'd0;
        end else if (q > 12'sd255) begin
            return 8'd255;
        end else begin
            return q[7:0];
        end
    endfunction

endpackage

// ----- rtl/y2b_matrix.sv -----
// ----------------------------------------------------------------------------
// y2b_matrix: color matrix datapath
// Combinational 3x3 multiply-add in Q10 with floor and clamp per channel.
// ----------------------------------------------------------------------------
module y2b_matrix (
    input  logic            i_mode,
    input  logic [7:0]      i_luma,
    input  logic [7:0]      i_chroma_blue,
    input  logic [7:0]      i_chroma_red,
    output y2b_pkg::t_byte  o_blue,
    output y2b_pkg::t_byte  o_green,
    output y2b_pkg::t_byte  o_red
);
    import y2b_pkg::*;

    logic signed [9:0] y_ofs;
    logic signed [9:0] u_ofs;
    logic signed [9:0] v_ofs;
    t_acc              y_term;
    t_coef             k_ub, k_ug, k_vg, k_vr;
    t_acc              sum_b, sum_g, sum_r;

    assign y_ofs = $signed({2'b00, i_luma}) - LUMA_OFS;
    assign u_ofs = $signed({2'b00, i_chroma_blue}) - CHROMA_OFS;
    assign v_ofs = $signed({2'b00, i_chroma_red}) - CHROMA_OFS;

    always_comb begin
        unique case (i_mode)
            MODE_STUDIO: begin
                y_term = t_acc'(C0_Y) * t_acc'(y_ofs);
                k_ub   = C0_UB;
                k_ug   = C0_UG;
                k_vg   = C0_VG;
                k_vr   = C0_VR;
            end
            MODE_ALT: begin
                // luma passes through: Y * 1024
                y_term = t_acc'({i_luma, 10'b0});
                k_ub   = C1_UB;
                k_ug   = C1_UG;
                k_vg   = C1_VG;
                k_vr   = C1_VR;
            end
            default: begin
                y_term = '0;
                k_ub   = '0;
                k_ug   = '0;
                k_vg   = '0;
                k_vr   = '0;
            end
        endcase
    end

    assign sum_b = y_term + t_acc'(k_ub) * t_acc'(u_ofs);
    assign sum_g = y_term + t_acc'(k_ug) * t_acc'(u_ofs) + t_acc'(k_vg) * t_acc'(v_ofs);
    assign sum_r = y_term + t_acc'(k_vr) * t_acc'(v_ofs);

    assign o_blue  = clamp_byte(sum_b);
    assign o_green = clamp_byte(sum_g);
    assign o_red   = clamp_byte(sum_r);

endmodule

// ----- rtl/yuv_to_bgr_pixel_converter_unit.sv -----
// ----------------------------------------------------------------------------
// yuv_to_bgr_pixel_converter_unit: YUV to BGR pixel converter
// One pixel per clock, two-stage pipeline, studio-range or alternate color matrix.
// ----------------------------------------------------------------------------
// Usage: drive a pixel on i_luma/i_chroma_blue/i_chroma_red with start high;
// busy never rises, so a request is taken every clock. The converted pixel
// appears on o_blue_out/o_green_out/o_red_out with o_strobe high for exactly
// one cycle; the receiver cannot stall and must take it. Throughput is one
// pixel per clock; the path is one input register, then the matrix
// multiply-add and clamp feed the result register. Matrix select
// (i_cfg_we/i_cfg_wdata) resets to 1 (alternate matrix, luma unscaled); 0
// picks studio-range BT.601 with the U and V green weights swapped. Change
// it only with no request in flight.
module yuv_to_bgr_pixel_converter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    // request
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_luma,
    input  logic [7:0] i_chroma_blue,
    input  logic [7:0] i_chroma_red,
    // result
    output logic       o_strobe,
    output logic [7:0] o_blue_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_red_out
);
    import y2b_pkg::*;

    logic       r_mode;
    logic       r_in_vld;
    logic [7:0] r_luma, r_cb, r_cr;
    logic       r_out_vld;
    t_byte      r_blue, r_green, r_red;
    t_byte      n_blue, n_green, n_red;
    logic       accept;

    // Fully pipelined: never back-pressures.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Matrix select register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ALT;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // Stage 1: capture request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_luma <= i_luma;
            r_cb   <= i_chroma_blue;
            r_cr   <= i_chroma_red;
        end
    end

    y2b_matrix u_matrix (
        .i_mode        (r_mode),
        .i_luma        (r_luma),
        .i_chroma_blue (r_cb),
        .i_chroma_red  (r_cr),
        .o_blue        (n_blue),
        .o_green       (n_green),
        .o_red         (n_red)
    );

    // Stage 2: result register, strobe lasts one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_blue  <= n_blue;
            r_green <= n_green;
            r_red   <= n_red;
        end
    end

    assign o_strobe    = r_out_vld;
    assign o_blue_out  = r_blue;
    assign o_green_out = r_green;
    assign o_red_out   = r_red;

endmodule

// ----- rtl/y2b_checker.sv -----
// ----------------------------------------------------------------------------
// y2b_checker: port-level checks for the YUV to BGR converter
// No back-pressure, request-to-result timing and reset behavior, bound to the top level.
// ----------------------------------------------------------------------------
module y2b_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe
);

    // never back-pressures
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // each request yields a result through the input and result registers
    a_req_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("result missing after request");

    // no result without a matching earlier request
    a_res_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 2))
        else $error("result without request");

    // reset clears the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");

endmodule

bind yuv_to_bgr_pixel_converter_unit y2b_checker u_y2b_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe)
);
